/* rtl/utf8s_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package utf8s_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int WIN_N  = 4;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic stop;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/utf8s_in_if.sv */
// Byte channel: one raw stream byte and its end-of-buffer flag per transfer.
`default_nettype none

interface utf8s_in_if;
    import utf8s_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

/* rtl/utf8s_out_if.sv */
// Code point channel: one decoded code point and its flags per transfer.
`default_nettype none

interface utf8s_out_if;
    import utf8s_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            run_last;
    logic            buffer_done;

    modport source (output valid, output code_point, output run_last, output buffer_done,
                    input ready);
    modport sink (input valid, input code_point, input run_last, input buffer_done,
                  output ready);
endinterface

`default_nettype wire

/* rtl/utf8s_ctrl.sv */
// Controller state machine: sequences byte load, result scan and window compaction.
`default_nettype none

module utf8s_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output utf8s_pkg::dp_cmd_t       cmd,
    input  wire utf8s_pkg::dp_stat_t stat
);
    import utf8s_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.stop)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/utf8s_dpath.sv */
// Datapath: byte window, scan position, sequence decode and output register.
`default_nettype none

module utf8s_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [utf8s_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                         buffer_end,
    input  wire utf8s_pkg::dp_cmd_t           cmd,
    output utf8s_pkg::dp_stat_t               stat,
    utf8s_out_if.source                       code_points
);
    import utf8s_pkg::*;

    typedef logic [WIN_N-1:0][BYTE_W-1:0] win_t;

    typedef struct packed {
        logic            hold;
        logic [CP_W-1:0] cp;
        logic [2:0]      adv;
    } dec_t;

    function automatic dec_t decode_at(input win_t w, input logic [2:0] n,
                                       input logic [1:0] q, input logic end_f);
        logic [BYTE_W-1:0] b;
        logic [1:0]        need;
        logic              bad;
        logic              shrt;
        logic [CP_W-1:0]   cp;
        logic [2:0]        idx;
        dec_t              d;
        b    = w[q];
        need = 2'd0;
        bad  = 1'b0;
        shrt = 1'b0;
        cp   = REPL_CP;
        case (b) inside
            8'b0???????: need = 2'd0;
            8'b110?????: need = 2'd1;
            8'b1110????: need = 2'd2;
            8'b11110???: need = 2'd3;
            default:     bad  = 1'b1;
        endcase
        for (int i = 1; i <= 3; i++)
        begin
            idx = {1'b0, q} + 3'(i);
            if ((2'(i) <= need) && !bad && !shrt)
            begin
                if (idx >= n)
                begin
                    shrt = 1'b1;
                end
                else if (w[idx[1:0]][7:6] != 2'b10)
                begin
                    bad = 1'b1;
                end
            end
        end
        case (need)
            2'd0: cp = bad ? REPL_CP : {13'd0, b};
            2'd1: cp = {10'd0, b[4:0], w[q + 2'd1][5:0]};
            2'd2: cp = {5'd0, b[3:0], w[q + 2'd1][5:0], w[q + 2'd2][5:0]};
            2'd3: cp = {b[2:0], w[q + 2'd1][5:0], w[q + 2'd2][5:0], w[q + 2'd3][5:0]};
            default: cp = REPL_CP;
        endcase
        d.hold = shrt && !end_f;
        d.cp   = (bad || shrt) ? REPL_CP : cp;
        d.adv  = (bad || shrt) ? 3'd1 : ({1'b0, need} + 3'd1);
        return d;
    endfunction

    win_t            win_reg;
    win_t            win_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic [1:0]      p_reg;
    logic [1:0]      p_next;
    logic            end_reg;
    logic            end_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] cp_next;
    logic            last_reg;
    logic            last_next;
    logic            done_reg;
    logic            done_next;

    logic [2:0] n;
    logic [2:0] pn;
    logic [2:0] pe;
    logic [2:0] rest;
    dec_t       cur;
    dec_t       nxt;

    assign n    = {1'b0, count_reg} + 3'd1;
    assign cur  = decode_at(win_reg, n, p_reg, end_reg);
    assign pn   = {1'b0, p_reg} + cur.adv;
    assign nxt  = decode_at(win_reg, n, pn[1:0], end_reg);
    assign pe   = cmd.emit ? pn : {1'b0, p_reg};
    assign rest = n - pe;

    assign stat.stop     = cur.hold || ({1'b0, p_reg} >= n);
    assign stat.last     = (pn >= n) || nxt.hold;
    assign stat.out_free = !out_valid_reg || code_points.ready;

    always_comb
    begin
        win_next       = win_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        last_next      = last_reg;
        done_next      = done_reg;

        if (out_valid_reg && code_points.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            win_next[count_reg] = data_byte;
            p_next              = 2'd0;
            end_next            = buffer_end;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            cp_next        = cur.cp;
            last_next      = stat.last;
            done_next      = stat.last && end_reg;
            p_next         = pn[1:0];
        end

        if (cmd.finish)
        begin
            count_next = (end_reg || (pe >= n)) ? 2'd0 : rest[1:0];
            for (int j = 0; j < WIN_N - 1; j++)
            begin
                win_next[j] = win_reg[pe[1:0] + 2'(j)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        p_reg    <= p_next;
        end_reg  <= end_next;
        cp_reg   <= cp_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign code_points.valid       = out_valid_reg;
    assign code_points.code_point  = cp_reg;
    assign code_points.run_last    = last_reg;
    assign code_points.buffer_done = done_reg;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result produced while output register is occupied");

    a_emit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (p_reg <= count_reg))
        else $error("scan position beyond window");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && end_reg) |=> (count_reg == 2'd0))
        else $error("pending bytes kept past buffer end");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("buffer_done without run_last");

endmodule

`default_nettype wire

/* rtl/utf8_stream_decoder_core.sv */
// Top level of the UTF-8 stream decoder.
// Usage:
//   bytes       : sink channel, one UTF-8 byte per transfer with buffer_end set on the
//                 last byte of a buffer.
//   code_points : source channel, one 21-bit code point per transfer; run_last marks
//                 the last result caused by a byte, buffer_done the final code point
//                 of a buffer. Invalid, stray or truncated bytes give U+FFFD.
//   After a byte is accepted, the scan gives one result per cycle, while the output
//   register is free, from a four-byte window (held lead and trail bytes plus the new
//   byte). A byte that only starts a sequence gives no result, one that completes a
//   sequence gives one, and a rescan burst at a broken sequence gives several.
//   A byte is registered in the window before its results reach the output register.
//   A lead byte is held with its trail bytes until the sequence completes, breaks,
//   or the buffer ends; the held bytes are cleared at each buffer end.
//   Reset clears the held-byte count and the output register; the block is ready
//   for a byte in the first cycle after reset.
//   When the receiver stalls, the finished result waits in the output register and
//   the scan holds; no new byte is accepted until the current one is fully decided.
`default_nettype none

module utf8_stream_decoder_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    utf8s_in_if.sink    bytes,
    utf8s_out_if.source code_points
);
    import utf8s_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign bytes.ready = in_ready;

    utf8s_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    utf8s_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (bytes.data_byte),
        .buffer_end  (bytes.buffer_end),
        .cmd         (cmd),
        .stat        (stat),
        .code_points (code_points)
    );

endmodule

`default_nettype wire
